>>> hw/rtl/spgd_pkg.sv
// shared types, codes and helpers for the spgd drive loop
`timescale 1ns / 1ps
package spgd_pkg;

  localparam int NCH_HW = 4;

  typedef logic signed [15:0] code_t;
  typedef logic signed [9:0]  pert_t;

  // configuration register indexes
  localparam logic [1:0] CFG_GAIN  = 2'd0;
  localparam logic [1:0] CFG_PSPAN = 2'd1;
  localparam logic [1:0] CFG_ISPAN = 2'd2;
  localparam logic [1:0] CFG_SEED  = 2'd3;

  localparam logic [19:0] GAIN_RST  = 20'd131072;
  localparam logic [14:0] PSPAN_RST = 15'd655;
  localparam logic [14:0] ISPAN_RST = 15'd6554;
  localparam logic [31:0] SEED_RST  = 32'd1;

  typedef struct packed {
    logic [19:0] gain;
    logic [14:0] pspan;
    logic [14:0] ispan;
    logic [31:0] seed;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    PH_BASE  = 2'd0,
    PH_PLUS  = 2'd1,
    PH_MINUS = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    MUL_V,
    MUL_DV,
    MUL_DIFF,
    MUL_GAIN
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_V_MUL,
    ST_V_WR,
    ST_DV_MUL,
    ST_DV_WR,
    ST_U_MUL1,
    ST_U_MUL2,
    ST_U_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic     latch_in;
    logic     wr_plus;
    logic     load_seed;
    logic     rng_step;
    mul_sel_t mul_sel;
    logic     wr_v_draw;
    logic     wr_dv;
    logic     wr_v_upd;
    logic     load_out;
    phase_t   out_phase;
  } dp_cmd_t;

  function automatic code_t sat16(input logic signed [17:0] x);
    code_t r;
    if (x > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/spgd_ctrl.sv
// sequencer for start, phase cycling, per-channel draws and updates
`timescale 1ns / 1ps
module spgd_ctrl #(
  parameter int CHANNELS = 4,
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output spgd_pkg::dp_cmd_t cmd,
  output logic [CH_W-1:0]   ch
);
  import spgd_pkg::*;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  state_t          state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  phase_t          phase_r, phase_nxt;
  logic            running_r, running_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      phase_r     <= PH_BASE;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      phase_r     <= phase_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    phase_nxt     = phase_r;
    running_nxt   = running_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;

    cmd.latch_in  = 1'b0;
    cmd.wr_plus   = 1'b0;
    cmd.load_seed = 1'b0;
    cmd.rng_step  = 1'b0;
    cmd.mul_sel   = MUL_V;
    cmd.wr_v_draw = 1'b0;
    cmd.wr_dv     = 1'b0;
    cmd.wr_v_upd  = 1'b0;
    cmd.load_out  = 1'b0;
    // phase_r already holds the phase of the result being built
    cmd.out_phase = phase_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          if (!in_mode) begin
            cmd.load_seed = 1'b1;
            ch_nxt        = '0;
            phase_nxt     = PH_BASE;
            running_nxt   = 1'b1;
            state_nxt     = ST_V_MUL;
          end else if (running_r) begin
            unique case (phase_r)
              PH_BASE: begin
                phase_nxt = PH_PLUS;
                state_nxt = ST_EMIT;
              end
              PH_PLUS: begin
                cmd.wr_plus = 1'b1;
                phase_nxt   = PH_MINUS;
                state_nxt   = ST_EMIT;
              end
              PH_MINUS: begin
                phase_nxt = PH_BASE;
                ch_nxt    = '0;
                state_nxt = ST_U_MUL1;
              end
              default: begin
                phase_nxt = PH_BASE;
                state_nxt = ST_EMIT;
              end
            endcase
          end
        end
      end
      ST_V_MUL: begin
        cmd.rng_step = 1'b1;
        cmd.mul_sel  = MUL_V;
        state_nxt    = ST_V_WR;
      end
      ST_V_WR: begin
        cmd.wr_v_draw = 1'b1;
        if (ch_r == LAST_CH) begin
          ch_nxt    = '0;
          state_nxt = ST_DV_MUL;
        end else begin
          ch_nxt    = ch_r + CH_W'(1);
          state_nxt = ST_V_MUL;
        end
      end
      ST_DV_MUL: begin
        cmd.rng_step = 1'b1;
        cmd.mul_sel  = MUL_DV;
        state_nxt    = ST_DV_WR;
      end
      ST_DV_WR: begin
        cmd.wr_dv = 1'b1;
        if (ch_r == LAST_CH) begin
          ch_nxt    = '0;
          state_nxt = ST_EMIT;
        end else begin
          ch_nxt    = ch_r + CH_W'(1);
          state_nxt = ST_DV_MUL;
        end
      end
      ST_U_MUL1: begin
        cmd.mul_sel = MUL_DIFF;
        state_nxt   = ST_U_MUL2;
      end
      ST_U_MUL2: begin
        cmd.mul_sel = MUL_GAIN;
        state_nxt   = ST_U_ACC;
      end
      ST_U_ACC: begin
        cmd.wr_v_upd = 1'b1;
        if (ch_r == LAST_CH) begin
          ch_nxt    = '0;
          state_nxt = ST_DV_MUL;
        end else begin
          ch_nxt    = ch_r + CH_W'(1);
          state_nxt = ST_U_MUL1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign ch        = ch_r;

endmodule

>>> hw/rtl/spgd_dp.sv
// drive datapath: generator, shared multiplier, channel state and result register
`timescale 1ns / 1ps
module spgd_dp #(
  parameter int CHANNELS = 4,
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                clk,
  input  spgd_pkg::cfg_regs_t cfg,
  input  spgd_pkg::dp_cmd_t   cmd,
  input  logic [CH_W-1:0]     ch,
  input  spgd_pkg::code_t     in_reading [spgd_pkg::NCH_HW],
  output spgd_pkg::code_t     out_drive [spgd_pkg::NCH_HW],
  output logic [1:0]          out_phase
);
  import spgd_pkg::*;

  code_t               v_r    [CHANNELS];
  pert_t               dv_r   [CHANNELS];
  code_t               plus_r [CHANNELS];
  code_t               rd_r   [CHANNELS];
  logic [31:0]         rng_r;
  logic signed [47:0]  prod_r;
  code_t               drive_r [NCH_HW];
  logic [1:0]          phase_r;

  logic [31:0]         x1, x2, x3;
  logic [15:0]         d;
  logic signed [15:0]  d_ctr;
  logic signed [16:0]  diff;
  logic signed [26:0]  mul_a;
  logic signed [20:0]  mul_b;
  logic signed [47:0]  prod;
  logic signed [15:0]  dv_raw;
  pert_t               dv_clamp;
  logic signed [16:0]  inc;
  code_t               v_upd;
  code_t               emit_val [NCH_HW];

  // xorshift32 step, draw is the upper half of the new word
  always_comb begin
    x1    = rng_r ^ (rng_r << 13);
    x2    = x1 ^ (x1 >> 17);
    x3    = x2 ^ (x2 << 5);
    d     = x3[31:16];
    d_ctr = {~d[15], d[14:0]};
  end

  assign diff = 17'(plus_r[ch]) - 17'(rd_r[ch]);

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_V: begin
        mul_a = {11'd0, d};
        mul_b = {6'd0, cfg.ispan};
      end
      MUL_DV: begin
        mul_a = 27'(d_ctr);
        mul_b = {6'd0, cfg.pspan};
      end
      MUL_DIFF: begin
        mul_a = 27'(diff);
        mul_b = 21'(dv_r[ch]);
      end
      MUL_GAIN: begin
        mul_a = prod_r[26:0];
        mul_b = {1'b0, cfg.gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // floor shift by 16, then clamp to the perturbation range
  always_comb begin
    dv_raw = prod_r[31:16];
    if (dv_raw > 16'sd511) begin
      dv_clamp = 10'sd511;
    end else if (dv_raw < -16'sd512) begin
      dv_clamp = -10'sd512;
    end else begin
      dv_clamp = dv_raw[9:0];
    end
  end

  assign inc   = prod_r[47:31];
  assign v_upd = sat16(18'(v_r[ch]) + 18'(inc));

  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (cmd.load_seed) begin
      rng_r <= (cfg.seed == 32'd0) ? 32'd1 : cfg.seed;
    end else if (cmd.rng_step) begin
      rng_r <= x3;
    end
    if (cmd.wr_v_draw) begin
      v_r[ch] <= {1'b0, prod_r[30:16]};
    end else if (cmd.wr_v_upd) begin
      v_r[ch] <= v_upd;
    end
    if (cmd.wr_dv) begin
      dv_r[ch] <= dv_clamp;
    end
    if (cmd.load_out) begin
      drive_r <= emit_val;
      phase_r <= cmd.out_phase;
    end
  end

  for (genvar j = 0; j < NCH_HW; j++) begin : g_ch
    if (j < CHANNELS) begin : g_act
      logic signed [16:0] sum;

      always_comb begin
        unique case (cmd.out_phase)
          PH_PLUS:  sum = 17'(v_r[j]) + 17'(dv_r[j]);
          PH_MINUS: sum = 17'(v_r[j]) - 17'(dv_r[j]);
          default:  sum = 17'(v_r[j]);
        endcase
      end

      assign emit_val[j] = sat16(18'(sum));

      always_ff @(posedge clk) begin
        if (cmd.latch_in) begin
          rd_r[j] <= in_reading[j];
        end
        if (cmd.wr_plus) begin
          plus_r[j] <= in_reading[j];
        end
      end
    end else begin : g_off
      assign emit_val[j] = '0;
    end
  end

  assign out_drive = drive_r;
  assign out_phase = phase_r;

endmodule

>>> hw/rtl/spgd_perturb_update_loop.sv
// top level of the spgd drive loop: configuration registers, sequencer and datapath
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  in       | in_valid/in_ready  | in_mode, in_reading_ch0..3
//  out      | out_valid/out_ready| out_drive_ch0..3, out_drive_phase
//  cfg      | cfg_valid/cfg_ready| cfg_index (0 gain, 1 pspan, 2 ispan, 3 seed), cfg_data
//
// one item at a time, all channels through one shared multiplier:
// start: draw each value, then each perturbation; baseline, plus: emit the drive;
// minus: update each channel, then draw fresh perturbations.
// a new item is taken while the previous result still waits in the output register.
// synchronous active-low reset; cfg_ready is always high.
`timescale 1ns / 1ps
module spgd_perturb_update_loop #(
  parameter int CHANNELS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic signed [15:0] in_reading_ch0,
  input  logic signed [15:0] in_reading_ch1,
  input  logic signed [15:0] in_reading_ch2,
  input  logic signed [15:0] in_reading_ch3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_drive_ch0,
  output logic signed [15:0] out_drive_ch1,
  output logic signed [15:0] out_drive_ch2,
  output logic signed [15:0] out_drive_ch3,
  output logic [1:0]         out_drive_phase,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import spgd_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_regs_t       cfg_r;
  dp_cmd_t         cmd;
  logic [CH_W-1:0] ch;
  code_t           rd_in [NCH_HW];
  code_t           drive [NCH_HW];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain  <= GAIN_RST;
      cfg_r.pspan <= PSPAN_RST;
      cfg_r.ispan <= ISPAN_RST;
      cfg_r.seed  <= SEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAIN:  cfg_r.gain  <= cfg_data[19:0];
        CFG_PSPAN: cfg_r.pspan <= cfg_data[14:0];
        CFG_ISPAN: cfg_r.ispan <= cfg_data[14:0];
        CFG_SEED:  cfg_r.seed  <= cfg_data;
        default:   cfg_r.seed  <= cfg_r.seed;
      endcase
    end
  end

  assign rd_in[0] = in_reading_ch0;
  assign rd_in[1] = in_reading_ch1;
  assign rd_in[2] = in_reading_ch2;
  assign rd_in[3] = in_reading_ch3;

  spgd_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .ch        (ch)
  );

  spgd_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .ch         (ch),
    .in_reading (rd_in),
    .out_drive  (drive),
    .out_phase  (out_drive_phase)
  );

  assign out_drive_ch0 = drive[0];
  assign out_drive_ch1 = drive[1];
  assign out_drive_ch2 = drive[2];
  assign out_drive_ch3 = drive[3];

endmodule

>>> test/tb.sv
// testbench for the spgd drive loop: directed table, then random phases checked by a predictor
`timescale 1ns / 1ps
module tb;
  import spgd_pkg::*;

  localparam int NUM_CH = 4;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = 105;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam code_t CODE_MAX = 16'sh7fff;
  localparam code_t CODE_MIN = 16'sh8000;

  typedef struct packed {
    phase_t      phase;
    code_t [3:0] drive;
  } drive_res_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CHECKED,
    ROW_SETTINGS
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             mode;
    code_t [3:0]      rd;
    drive_res_t       want;
    logic [3:0][31:0] words;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  code_t in_reading_ch0 = '0;
  code_t in_reading_ch1 = '0;
  code_t in_reading_ch2 = '0;
  code_t in_reading_ch3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  code_t out_drive_ch0;
  code_t out_drive_ch1;
  code_t out_drive_ch2;
  code_t out_drive_ch3;
  logic [1:0] out_drive_phase;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  spgd_perturb_update_loop #(.CHANNELS(NUM_CH)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_reading_ch0(in_reading_ch0),
    .in_reading_ch1(in_reading_ch1),
    .in_reading_ch2(in_reading_ch2),
    .in_reading_ch3(in_reading_ch3),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_drive_ch0(out_drive_ch0),
    .out_drive_ch1(out_drive_ch1),
    .out_drive_ch2(out_drive_ch2),
    .out_drive_ch3(out_drive_ch3),
    .out_drive_phase(out_drive_phase),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // loop state as the predictor sees it
  cfg_regs_t loop_cfg = '{gain: GAIN_RST, pspan: PSPAN_RST, ispan: ISPAN_RST, seed: SEED_RST};
  code_t  v_reg [NUM_CH];
  pert_t  dv_reg [NUM_CH];
  code_t  plus_rd [NUM_CH];
  phase_t loop_phase = PH_BASE;
  logic [31:0] rng_state = 32'd1;
  bit running = 1'b0;

  drive_res_t pending_drives [$];
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  bit hold_out = 1'b0;
  int n_fail = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_restarts = 0;
  int n_settings = 0;
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // xorshift32 step, draw is the upper half of the new word
  function automatic logic [15:0] next_draw();
    logic [31:0] x;
    x = rng_state;
    x ^= x << 13;
    x ^= x >> 17;
    x ^= x << 5;
    rng_state = x;
    return x[31:16];
  endfunction

  function automatic code_t clamp_code(input longint x);
    if (x > 32767) return CODE_MAX;
    if (x < -32768) return CODE_MIN;
    return code_t'(x);
  endfunction

  function automatic pert_t next_dv();
    longint p;
    p = (longint'(next_draw()) - 64'sd32768) * longint'(loop_cfg.pspan);
    p = p >>> 16;
    if (p > 511) p = 511;
    if (p < -512) p = -512;
    return pert_t'(p);
  endfunction

  function automatic drive_res_t form_drive(input int sign, input phase_t ph);
    drive_res_t r;
    int j;
    r = '0;
    for (j = 0; j < 4; j++) begin
      if (j < NUM_CH) begin
        r.drive[j] = clamp_code(longint'(v_reg[j]) + sign * longint'(dv_reg[j]));
      end
    end
    r.phase = ph;
    return r;
  endfunction

  // advances the loop by one item; returns 0 when the item gives no drive
  function automatic bit next_drive(input logic mode, input code_t [3:0] rd,
                                    output drive_res_t res);
    longint diff;
    longint p;
    int j;
    res = '0;
    if (!mode) begin
      rng_state = (loop_cfg.seed != 0) ? loop_cfg.seed : 32'd1;
      for (j = 0; j < NUM_CH; j++) begin
        v_reg[j] = code_t'((longint'(next_draw()) * longint'(loop_cfg.ispan)) >>> 16);
      end
      for (j = 0; j < NUM_CH; j++) begin
        dv_reg[j] = next_dv();
      end
      loop_phase = PH_BASE;
      running = 1'b1;
      res = form_drive(0, PH_BASE);
      return 1'b1;
    end
    if (!running) return 1'b0;
    case (loop_phase)
      PH_BASE: begin
        loop_phase = PH_PLUS;
        res = form_drive(1, PH_PLUS);
      end
      PH_PLUS: begin
        for (j = 0; j < NUM_CH; j++) begin
          plus_rd[j] = rd[j];
        end
        loop_phase = PH_MINUS;
        res = form_drive(-1, PH_MINUS);
      end
      default: begin
        // gradient step from the plus/minus difference, then fresh perturbations
        for (j = 0; j < NUM_CH; j++) begin
          diff = longint'(plus_rd[j]) - longint'(rd[j]);
          p = diff * longint'(dv_reg[j]) * longint'(loop_cfg.gain);
          v_reg[j] = clamp_code(longint'(v_reg[j]) + (p >>> 31));
        end
        for (j = 0; j < NUM_CH; j++) begin
          dv_reg[j] = next_dv();
        end
        loop_phase = PH_BASE;
        res = form_drive(0, PH_BASE);
      end
    endcase
    return 1'b1;
  endfunction

  task automatic send_item(input logic mode, input code_t [3:0] rd, input bit typed,
                           input drive_res_t typed_res);
    int gap;
    drive_res_t res;
    bit has_res;
    gap = send_gaps ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_reading_ch0 <= rd[0];
    in_reading_ch1 <= rd[1];
    in_reading_ch2 <= rd[2];
    in_reading_ch3 <= rd[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!mode && running) n_restarts++;
    has_res = next_drive(mode, rd, res);
    if (typed) res = typed_res;
    if (has_res) pending_drives.push_back(res);
    n_items++;
  endtask

  // stop offering items, let every drive come back and the block go idle
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [3:0][31:0] words);
    int i;
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= words[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (2'(i))
        CFG_GAIN:  loop_cfg.gain = words[i][19:0];
        CFG_PSPAN: loop_cfg.pspan = words[i][14:0];
        CFG_ISPAN: loop_cfg.ispan = words[i][14:0];
        CFG_SEED:  loop_cfg.seed = words[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      n_fail++;
    end
  endtask

  // result side: random stalls, plus one long hold-off when asked
  initial begin
    int gap;
    drive_res_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
      gap = recv_gaps ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_drives.size() == 0) begin
        $error("drive result with no item waiting: phase %0d", out_drive_phase);
        n_fail++;
      end else begin
        want = pending_drives.pop_front();
        check_field("drive_ch0", want.drive[0], out_drive_ch0);
        check_field("drive_ch1", want.drive[1], out_drive_ch1);
        check_field("drive_ch2", want.drive[2], out_drive_ch2);
        check_field("drive_ch3", want.drive[3], out_drive_ch3);
        check_field("drive_phase", {14'd0, want.phase}, {14'd0, out_drive_phase});
        n_checked++;
      end
    end
  end

  function automatic stim_row_t item_row(input logic mode, input code_t [3:0] rd);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.mode = mode;
    r.rd = rd;
    return r;
  endfunction

  // all four channels expected at the same code
  function automatic stim_row_t checked_row(input logic mode, input code_t [3:0] rd,
                                            input code_t d, input phase_t ph);
    stim_row_t r;
    r = item_row(mode, rd);
    r.kind = ROW_CHECKED;
    r.want.drive = {4{d}};
    r.want.phase = ph;
    return r;
  endfunction

  function automatic stim_row_t settings_row(input logic [31:0] gain, input logic [31:0] pspan,
                                             input logic [31:0] ispan, input logic [31:0] seed);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SETTINGS;
    r.words[CFG_GAIN] = gain;
    r.words[CFG_PSPAN] = pspan;
    r.words[CFG_ISPAN] = ispan;
    r.words[CFG_SEED] = seed;
    return r;
  endfunction

  function automatic code_t pick_reading();
    case ($urandom_range(0, 7))
      0: return CODE_MAX;
      1: return CODE_MIN;
      2: return code_t'($urandom_range(0, 64)) - 16'sd32;
      default: return code_t'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_word(input logic [31:0] top, input logic [31:0] dflt);
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return top;
      2: return dflt;
      3: return $urandom_range(0, top);
      default: return $urandom();  // upper bits beyond the register are dropped
    endcase
  endfunction

  initial begin
    stim_row_t plan [$];
    stim_row_t row;
    logic [3:0][31:0] words;
    code_t [3:0] rd;
    logic mode;
    int p;
    int k;
    int j;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // readings before any start are dropped
    plan.push_back(item_row(1'b1, {4{CODE_MAX}}));
    plan.push_back(item_row(1'b1, {4{CODE_MIN}}));
    plan.push_back(item_row(1'b0, {CODE_MAX, CODE_MIN, 16'sd1, -16'sd1}));
    plan.push_back(item_row(1'b1, {4{16'sd0}}));
    // zero spans: every drive stays at zero through a whole cycle
    plan.push_back(settings_row(32'(GAIN_RST), 32'd0, 32'd0, SEED_RST));
    plan.push_back(checked_row(1'b0, {CODE_MIN, CODE_MAX, CODE_MIN, CODE_MAX}, 16'sd0, PH_BASE));
    plan.push_back(checked_row(1'b1, {4{16'sd0}}, 16'sd0, PH_PLUS));
    plan.push_back(checked_row(1'b1, {4{CODE_MAX}}, 16'sd0, PH_MINUS));
    plan.push_back(checked_row(1'b1, {4{CODE_MIN}}, 16'sd0, PH_BASE));
    // full-scale spans and gain, zero seed; extreme plus/minus differences
    plan.push_back(settings_row(32'hFFFFF, 32'h7FFF, 32'h7FFF, 32'd0));
    plan.push_back(item_row(1'b0, {4{16'sd0}}));
    plan.push_back(item_row(1'b1, {4{16'sd0}}));
    plan.push_back(item_row(1'b1, {4{CODE_MAX}}));
    plan.push_back(item_row(1'b1, {4{CODE_MIN}}));
    plan.push_back(item_row(1'b1, {4{16'sd0}}));
    plan.push_back(item_row(1'b1, {4{CODE_MIN}}));
    plan.push_back(item_row(1'b1, {4{CODE_MAX}}));
    plan.push_back(item_row(1'b1, {4{16'sd0}}));
    // restart in the middle of a cycle
    plan.push_back(item_row(1'b0, {4{CODE_MAX}}));
    plan.push_back(item_row(1'b1, {4{16'sd100}}));
    plan.push_back(item_row(1'b1, {4{-16'sd100}}));
    plan.push_back(item_row(1'b0, {4{CODE_MIN}}));
    plan.push_back(settings_row(32'd0, 32'(PSPAN_RST), 32'(ISPAN_RST), 32'hFFFFFFFF));
    plan.push_back(item_row(1'b0, {4{16'sd0}}));
    plan.push_back(item_row(1'b1, {4{16'sd5}}));
    plan.push_back(item_row(1'b1, {CODE_MAX, CODE_MIN, 16'sd7, -16'sd7}));
    plan.push_back(item_row(1'b1, {CODE_MIN, CODE_MAX, -16'sd7, 16'sd7}));

    foreach (plan[i]) begin
      row = plan[i];
      case (row.kind)
        ROW_SETTINGS: begin
          quiesce();
          load_settings(row.words);
        end
        ROW_CHECKED: send_item(row.mode, row.rd, 1'b1, row.want);
        default:     send_item(row.mode, row.rd, 1'b0, '0);
      endcase
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      words[CFG_GAIN] = pick_word(32'hFFFFF, 32'(GAIN_RST));
      words[CFG_PSPAN] = pick_word(32'h7FFF, 32'(PSPAN_RST));
      words[CFG_ISPAN] = pick_word(32'h7FFF, 32'(ISPAN_RST));
      words[CFG_SEED] = pick_word(32'hFFFFFFFF, SEED_RST);
      load_settings(words);
      case (p % 4)
        0: begin send_gaps = 1'b1; recv_gaps = 1'b1; end
        1: begin send_gaps = 1'b0; recv_gaps = 1'b0; end
        2: begin send_gaps = 1'b1; recv_gaps = 1'b0; end
        default: begin send_gaps = 1'b0; recv_gaps = 1'b1; end
      endcase
      // block fills up behind a stalled result port while items keep coming
      if (p == 2) hold_out = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 5 && k == PHASE_ITEMS / 2) quiesce();
        // odd phases keep running across the settings change
        mode = !((k == 0 && p % 2 == 0) || $urandom_range(0, 39) == 0);
        for (j = 0; j < 4; j++) begin
          rd[j] = pick_reading();
        end
        send_item(mode, rd, 1'b0, '0);
      end
    end
    quiesce();

    $display("run covered %0d items, %0d restarts, %0d register settings",
             n_items, n_restarts, n_settings);
    $display("%0d drive results compared with the loop predictor, %0d mismatches",
             n_checked, n_fail);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/spgd_pkg.sv
hw/rtl/spgd_ctrl.sv
hw/rtl/spgd_dp.sv
hw/rtl/spgd_perturb_update_loop.sv
test/tb.sv
